@@ rtl/core/mfls_pkg.sv @@
// shared types, codes and helpers for the mono framebuffer line sender
package mfls_pkg;

  // field widths of one input item and one result item
  localparam int MODE_W = 2;
  localparam int POS_W  = 8;
  localparam int SIZE_W = 9;
  localparam int BYTE_W = 8;

  // operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL = 2'd0,
    MODE_RECT  = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_SEND  = 2'd3
  } mode_t;

  // start request from the control block to the line transmitter
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] hdr;
  } tx_req_t;

  // reverse the bit order of one byte
  function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] t;
    t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    return t;
  endfunction

endpackage

@@ rtl/core/mfls_in_if.sv @@
// input channel: one drawing or send command per item
interface mfls_in_if;
  import mfls_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  x_pos;
  logic [POS_W-1:0]  y_pos;
  logic [SIZE_W-1:0] rect_width;
  logic [SIZE_W-1:0] rect_height;
  logic              white;

  modport source (
    output valid, mode, x_pos, y_pos, rect_width, rect_height, white,
    input  ready
  );
  modport sink (
    input  valid, mode, x_pos, y_pos, rect_width, rect_height, white,
    output ready
  );
endinterface

@@ rtl/core/mfls_out_if.sv @@
// result channel: one panel byte per item
interface mfls_out_if;
  import mfls_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/core/mfls_ram.sv @@
// generic single-clock ram, one write port, one registered read port
module mfls_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/mfls_line_tx.sv @@
// line transmitter: header byte, buffered line bytes, zero trailer
module mfls_line_tx #(
  parameter int LINE_BYTES    = 32,
  parameter int TRAILER_BYTES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mfls_pkg::tx_req_t       req,
  input  logic [LINE_BYTES*8-1:0] line,
  output logic                    busy,
  mfls_out_if.source              out_ch
);
  import mfls_pkg::*;

  localparam int TOTAL = 1 + LINE_BYTES + TRAILER_BYTES;
  localparam int CNT_W = $clog2(TOTAL);
  localparam int ROW_W = LINE_BYTES * 8;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] hdr_r, hdr_nxt;
  logic [ROW_W-1:0]  line_r, line_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              slot_free;
  logic              is_data;

  assign slot_free = !ovalid_r || out_ch.ready;
  assign is_data   = (cnt_r != '0) && (cnt_r <= CNT_W'(LINE_BYTES));

  // next byte selection and line shift
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    hdr_nxt    = hdr_r;
    line_nxt   = line_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (busy_r && slot_free) begin
      ovalid_nxt = 1'b1;
      olast_nxt  = (cnt_r == CNT_W'(TOTAL - 1));
      if (cnt_r == '0) begin
        obyte_nxt = hdr_r;
      end else if (is_data) begin
        obyte_nxt = flip_bits(line_r[BYTE_W-1:0]);
        line_nxt  = line_r >> BYTE_W;
      end else begin
        obyte_nxt = '0;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TOTAL - 1)) begin
        busy_nxt = 1'b0;
      end
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      hdr_nxt  = req.hdr;
      line_nxt = line;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    hdr_r   <= hdr_nxt;
    line_r  <= line_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign busy             = busy_r;
  assign out_ch.valid     = ovalid_r;
  assign out_ch.out_byte  = obyte_r;
  assign out_ch.last_byte = olast_r;

endmodule

@@ rtl/core/mono_framebuffer_line_sender_unit.sv @@
// top level: frame store row update control and line send
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode, x_pos, y_pos, rect_width, rect_height, white
//   out_ch   out  valid/ready        out_byte, last_byte
//
// one line per ram word; a pixel is one read and one write, a rectangle a read and a write per row
// fill all needs no pass over the store: per-row flags plus a fill value stand in for the store
// a send reads the line and hands it to the transmitter, then 1 + LINE_BYTES + TRAILER_BYTES bytes
// leave one per cycle while out_ch.ready is high; meanwhile further items are accepted
// reset clears the row flags and fill value at once; there is no clearing pass
// out_ch.ready low holds the current byte; a new send waits for the previous line
module mono_framebuffer_line_sender_unit #(
  parameter int PANEL_WIDTH   = 256,
  parameter int PANEL_HEIGHT  = 256,
  parameter int TRAILER_BYTES = 4
) (
  input logic        clk,
  input logic        rst_n,
  mfls_in_if.sink    in_ch,
  mfls_out_if.source out_ch
);
  import mfls_pkg::*;

  localparam int LINE_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int ROW_W      = LINE_BYTES * 8;
  localparam int AW         = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_LOAD
  } state_t;

  state_t            state_r;
  logic              send_r;
  logic              white_r;
  logic              fill_r;
  logic [POS_W-1:0]  x_r;
  logic [SIZE_W-1:0] xe_r;
  logic [SIZE_W-1:0] ye_r;
  logic [SIZE_W-1:0] row_r;
  logic [PANEL_HEIGHT-1:0] row_valid_r;

  logic              accept;
  mode_t             mode;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [SIZE_W:0]   x_sum, y_sum;
  logic [SIZE_W-1:0] xe_clip, ye_clip;
  logic              rect_empty;
  logic [AW-1:0]     row_idx;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  mask;
  logic [ROW_W-1:0]  new_row;
  logic              ram_we, ram_re;
  logic              tx_busy;
  tx_req_t           tx_req;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign mode        = mode_t'(in_ch.mode);
  assign row_idx     = row_r[AW-1:0];

  // a pixel is a one by one rectangle; clip both ends against the panel
  always_comb begin
    w_eff = (mode == MODE_PIXEL) ? SIZE_W'(1) : in_ch.rect_width;
    h_eff = (mode == MODE_PIXEL) ? SIZE_W'(1) : in_ch.rect_height;
    x_sum = (SIZE_W + 1)'(in_ch.x_pos) + (SIZE_W + 1)'(w_eff);
    y_sum = (SIZE_W + 1)'(in_ch.y_pos) + (SIZE_W + 1)'(h_eff);
    xe_clip = (x_sum > (SIZE_W + 1)'(PANEL_WIDTH)) ? SIZE_W'(PANEL_WIDTH)
                                                   : x_sum[SIZE_W-1:0];
    ye_clip = (y_sum > (SIZE_W + 1)'(PANEL_HEIGHT)) ? SIZE_W'(PANEL_HEIGHT)
                                                    : y_sum[SIZE_W-1:0];
    rect_empty = (SIZE_W'(in_ch.x_pos) >= SIZE_W'(PANEL_WIDTH))
              || (SIZE_W'(in_ch.y_pos) >= SIZE_W'(PANEL_HEIGHT))
              || (w_eff == '0) || (h_eff == '0);
  end

  // column mask of the current item
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      mask[i] = (SIZE_W'(i) >= SIZE_W'(x_r)) && (SIZE_W'(i) < xe_r);
    end
  end

  // rows never written since the last fill read as the fill value
  assign cur_row = row_valid_r[row_idx] ? ram_rdata : {ROW_W{fill_r}};
  assign new_row = white_r ? (cur_row | mask) : (cur_row & ~mask);

  assign ram_re = (state_r == S_READ);
  assign ram_we = (state_r == S_WRITE);

  assign tx_req.start = (state_r == S_LOAD) && !tx_busy;
  assign tx_req.hdr   = flip_bits(row_r[BYTE_W-1:0]);

  // control state machine and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= 1'b0;
      row_valid_r <= '0;
      send_r      <= 1'b0;
      white_r     <= 1'b0;
      x_r         <= '0;
      xe_r        <= '0;
      ye_r        <= '0;
      row_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            send_r  <= (mode == MODE_SEND);
            white_r <= in_ch.white;
            x_r     <= in_ch.x_pos;
            xe_r    <= xe_clip;
            ye_r    <= ye_clip;
            row_r   <= SIZE_W'(in_ch.y_pos);
            unique case (mode)
              MODE_FILL: begin
                fill_r      <= in_ch.white;
                row_valid_r <= '0;
              end
              MODE_SEND: begin
                if (SIZE_W'(in_ch.y_pos) < SIZE_W'(PANEL_HEIGHT)) begin
                  state_r <= S_READ;
                end
              end
              MODE_PIXEL, MODE_RECT: begin
                if (!rect_empty) begin
                  state_r <= S_READ;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state_r <= send_r ? S_LOAD : S_WRITE;
        end
        S_WRITE: begin
          row_valid_r[row_idx] <= 1'b1;
          if (row_r + SIZE_W'(1) == ye_r) begin
            state_r <= S_IDLE;
          end else begin
            row_r   <= row_r + SIZE_W'(1);
            state_r <= S_READ;
          end
        end
        S_LOAD: begin
          if (!tx_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // frame store, one line per word
  mfls_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PANEL_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_idx),
    .wdata (new_row),
    .re    (ram_re),
    .raddr (row_idx),
    .rdata (ram_rdata)
  );

  // byte serializer with output register
  mfls_line_tx #(
    .LINE_BYTES    (LINE_BYTES),
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_tx (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tx_req),
    .line   (cur_row),
    .busy   (tx_busy),
    .out_ch (out_ch)
  );

endmodule

@@ tb/sv/mfls_panel_byte_checker.sv @@
`timescale 1ns / 100ps
// checker: frame store predictor and panel byte comparison for the line sender
module mfls_panel_byte_checker #(
  parameter int PANEL_WIDTH   = 256,
  parameter int PANEL_HEIGHT  = 256,
  parameter int TRAILER_BYTES = 4
) (
  input  logic clk,
  input  logic rst_n,
  mfls_in_if   in_mon,
  mfls_out_if  out_mon,
  output int   mismatch_count,
  output int   bytes_pending
);
  import mfls_pkg::*;

  localparam int LINE_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int LINE_BITS  = LINE_BYTES * 8;
  localparam int SEND_BYTES = 1 + LINE_BYTES + TRAILER_BYTES;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } panel_byte_t;

  // one row vector per line, pixel x at bit LINE_BITS-1-x (msb-first bytes)
  bit [LINE_BITS-1:0] image [PANEL_HEIGHT];
  panel_byte_t        panel_bytes_q [$];
  panel_byte_t        head;

  // update the image or queue the bytes of one line send
  task automatic draw_or_send(input mode_t m, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [SIZE_W-1:0] w,
                              input logic [SIZE_W-1:0] h, input logic white);
    int                 x_end;
    int                 y_end;
    bit [LINE_BITS-1:0] cols;
    bit [LINE_BITS-1:0] row;
    logic [BYTE_W-1:0]  addr;
    panel_byte_t        pb;
    case (m)
      MODE_PIXEL: begin
        if (x < PANEL_WIDTH && y < PANEL_HEIGHT) image[y][LINE_BITS-1-x] = white;
      end
      MODE_RECT: begin
        x_end = int'(x) + int'(w);
        if (x_end > PANEL_WIDTH) x_end = PANEL_WIDTH;
        y_end = int'(y) + int'(h);
        if (y_end > PANEL_HEIGHT) y_end = PANEL_HEIGHT;
        cols = '0;
        for (int i = x; i < x_end; i++) cols[LINE_BITS-1-i] = 1'b1;
        for (int j = y; j < y_end; j++) begin
          image[j] = white ? (image[j] | cols) : (image[j] & ~cols);
        end
      end
      MODE_FILL: begin
        // padding bits of a partial last byte are filled too
        for (int j = 0; j < PANEL_HEIGHT; j++) image[j] = {LINE_BITS{white}};
      end
      default: begin
        if (y < PANEL_HEIGHT) begin
          // bit-reversed line address, line bytes, zero trailer
          for (int k = 0; k < 8; k++) addr[k] = y[7-k];
          row = image[y];
          for (int n = 0; n < SEND_BYTES; n++) begin
            if (n == 0) pb.data = addr;
            else if (n <= LINE_BYTES) pb.data = row[LINE_BITS-1-8*(n-1) -: 8];
            else pb.data = '0;
            pb.last = (n == SEND_BYTES - 1);
            panel_bytes_q.push_back(pb);
          end
        end
      end
    endcase
  endtask

  // compare accepted bytes, then predict from the accepted command
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PANEL_HEIGHT; j++) image[j] = '0;
      panel_bytes_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (panel_bytes_q.size() == 0) begin
          $display("%0t ns: unexpected byte, expected none, actual out_byte %02h last_byte %b",
                   $time, out_mon.out_byte, out_mon.last_byte);
          mismatch_count = mismatch_count + 1;
        end else begin
          head = panel_bytes_q.pop_front();
          if (out_mon.out_byte !== head.data) begin
            $display("%0t ns: out_byte mismatch, expected %02h actual %02h",
                     $time, head.data, out_mon.out_byte);
            mismatch_count = mismatch_count + 1;
          end
          if (out_mon.last_byte !== head.last) begin
            $display("%0t ns: last_byte mismatch, expected %b actual %b",
                     $time, head.last, out_mon.last_byte);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        draw_or_send(mode_t'(in_mon.mode), in_mon.x_pos, in_mon.y_pos,
                     in_mon.rect_width, in_mon.rect_height, in_mon.white);
      end
    end
    bytes_pending = panel_bytes_q.size();
  end

endmodule

@@ tb/sv/mono_framebuffer_line_sender_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, drawing and send commands, final verdict
module mono_framebuffer_line_sender_unit_tb;
  import mfls_pkg::*;

  localparam int PANEL_WIDTH   = 256;
  localparam int PANEL_HEIGHT  = 256;
  localparam int TRAILER_BYTES = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int PHASE_ITEMS   = 115;

  logic clk;
  logic rst_n;
  logic accepted;
  logic idling;
  logic out_ready = 1'b1;
  int   stall_left;
  int   cycle_count;
  int   mismatch_count;
  int   bytes_pending;

  mfls_in_if  in_ch ();
  mfls_out_if out_ch ();

  assign out_ch.ready = out_ready;

  mono_framebuffer_line_sender_unit #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .TRAILER_BYTES(TRAILER_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mfls_panel_byte_checker #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .TRAILER_BYTES(TRAILER_BYTES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatch_count(mismatch_count),
    .bytes_pending (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // item handshake seen at the rising edge, read by the driver at the falling edge
  always @(posedge clk) begin
    accepted <= in_ch.valid && in_ch.ready;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mono_framebuffer_line_sender_unit_tb failed");
      $finish;
    end
  end

  // result side stalls in random bursts while idling is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one command, with an optional gap before it, and wait for acceptance
  task automatic issue(input mode_t m, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                       input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                       input logic white);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.x_pos       <= x;
    in_ch.y_pos       <= y;
    in_ch.rect_width  <= w;
    in_ch.rect_height <= h;
    in_ch.white       <= white;
    do @(negedge clk); while (accepted !== 1'b1);
  endtask

  initial begin
    int                pick;
    mode_t             m;
    logic [POS_W-1:0]  rx;
    logic [POS_W-1:0]  ry;
    logic [POS_W-1:0]  band;
    logic [SIZE_W-1:0] rw;
    logic [SIZE_W-1:0] rh;
    rst_n             = 1'b0;
    idling            = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_PIXEL;
    in_ch.x_pos       = '0;
    in_ch.y_pos       = '0;
    in_ch.rect_width  = '0;
    in_ch.rect_height = '0;
    in_ch.white       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, byte boundaries, clipping, fills, sends of the store after reset
    issue(MODE_SEND, 8'($urandom), 8'd0, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_SEND, 8'($urandom), 8'd255, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_PIXEL, 8'd0, 8'd0, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_PIXEL, 8'd255, 8'd255, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_PIXEL, 8'd255, 8'd0, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_PIXEL, 8'd0, 8'd255, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_SEND, 8'($urandom), 8'd0, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_SEND, 8'($urandom), 8'd255, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_PIXEL, 8'd0, 8'd0, 9'($urandom), 9'($urandom), 1'b0);
    issue(MODE_PIXEL, 8'd7, 8'd0, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_PIXEL, 8'd8, 8'd0, 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_SEND, 8'($urandom), 8'd0, 9'($urandom), 9'($urandom), 1'($urandom));
    // zero width and zero height write nothing
    issue(MODE_RECT, 8'd10, 8'd20, 9'd0, 9'd5, 1'b1);
    issue(MODE_RECT, 8'd10, 8'd20, 9'd5, 9'd0, 1'b1);
    issue(MODE_RECT, 8'd3, 8'd20, 9'd13, 9'd2, 1'b1);
    issue(MODE_SEND, 8'($urandom), 8'd20, 9'($urandom), 9'($urandom), 1'($urandom));
    // rectangles past the right and bottom edges, sizes above the panel
    issue(MODE_RECT, 8'd250, 8'd250, 9'd256, 9'd256, 1'b1);
    issue(MODE_RECT, 8'd240, 8'd252, 9'd511, 9'd511, 1'b0);
    issue(MODE_SEND, 8'($urandom), 8'd250, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_SEND, 8'($urandom), 8'd253, 9'($urandom), 9'($urandom), 1'($urandom));
    // fill all white and black
    issue(MODE_FILL, 8'($urandom), 8'($urandom), 9'($urandom), 9'($urandom), 1'b1);
    issue(MODE_PIXEL, 8'd100, 8'd7, 9'($urandom), 9'($urandom), 1'b0);
    issue(MODE_SEND, 8'($urandom), 8'd7, 9'($urandom), 9'($urandom), 1'($urandom));
    issue(MODE_FILL, 8'($urandom), 8'($urandom), 9'($urandom), 9'($urandom), 1'b0);
    issue(MODE_SEND, 8'($urandom), 8'd7, 9'($urandom), 9'($urandom), 1'($urandom));

    // random: writes and sends mostly within a band of 8 lines per phase
    for (int phase = 0; phase < 4; phase++) begin
      idling <= (phase % 2 == 0);
      band = 8'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) m = MODE_PIXEL;
        else if (pick < 60) m = MODE_RECT;
        else if (pick < 63) m = MODE_FILL;
        else m = MODE_SEND;
        rx = 8'($urandom);
        if ($urandom_range(0, 4) == 0) ry = 8'($urandom);
        else ry = band + 8'($urandom_range(0, 7));
        // mostly small rectangles, now and then any size the fields allow
        if ($urandom_range(0, 19) == 0) rw = 9'($urandom_range(0, 511));
        else rw = 9'($urandom_range(0, 16));
        if ($urandom_range(0, 19) == 0) rh = 9'($urandom_range(0, 511));
        else rh = 9'($urandom_range(0, 8));
        issue(m, rx, ry, rw, rh, 1'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    // drain outstanding bytes, then watch for stray ones
    while (bytes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("mono_framebuffer_line_sender_unit_tb passed");
    end else begin
      $display("mono_framebuffer_line_sender_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mfls_pkg.sv
rtl/core/mfls_in_if.sv
rtl/core/mfls_out_if.sv
rtl/core/mfls_ram.sv
rtl/core/mfls_line_tx.sv
rtl/core/mono_framebuffer_line_sender_unit.sv
tb/sv/mfls_panel_byte_checker.sv
tb/sv/mono_framebuffer_line_sender_unit_tb.sv
